@@ rtl/wgm_pkg.sv @@
// Shared types, constants and helpers for the wildcard glob matcher.
package wgm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int POS_N = PATTERN_MAX + 1;
	localparam int POS_W = $clog2(POS_N);
	localparam int CL_LVLS = $clog2(POS_N);

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_ANY = 8'h3F;
	localparam logic [7:0] CH_ESC = 8'h5C;

	localparam logic [2:0] REG_PAT_A = 3'd0;
	localparam logic [2:0] REG_PAT_B = 3'd1;
	localparam logic [2:0] REG_PAT_C = 3'd2;
	localparam logic [2:0] REG_PAT_D = 3'd3;
	localparam logic [2:0] REG_LEN = 3'd4;

	typedef enum logic [2:0] {
		K_NONE,
		K_STAR,
		K_ANY,
		K_LIT,
		K_ESC
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] lit_ch;
	} pat_cell_t;

	typedef struct packed {
		logic stay;
		logic step1;
		logic step2;
	} cell_link_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

@@ rtl/wgm_closure.sv @@
// Star closure: log-depth prefix spread of reached positions across star runs.
module wgm_closure import wgm_pkg::*; (
	input  logic [POS_N-1:0] set_in,
	input  logic [POS_N-1:0] prop,
	output logic [POS_N-1:0] set_out
);

	logic [POS_N-1:0] g_lvl [0:CL_LVLS];
	logic [POS_N-1:0] p_lvl [0:CL_LVLS];

	always_comb begin
		g_lvl[0] = set_in;
		p_lvl[0] = prop;
		for (int l = 0; l < CL_LVLS; l++) begin
			for (int j = 0; j < POS_N; j++) begin
				if (j >= (1 << l)) begin
					g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
					p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
				end else begin
					g_lvl[l+1][j] = g_lvl[l][j];
					p_lvl[l+1][j] = p_lvl[l][j];
				end
			end
		end
	end

	// the last propagate level only feeds a fold of itself
	assign set_out = g_lvl[CL_LVLS] | (g_lvl[CL_LVLS] & p_lvl[CL_LVLS]);

endmodule

@@ rtl/wgm_decode.sv @@
// Pattern decoder: classifies every pattern position, registered.
module wgm_decode import wgm_pkg::*; (
	input  logic                       clk,
	input  logic [PATTERN_MAX*8-1:0]   pattern,
	input  logic [5:0]                 pattern_length,
	output pat_cell_t [POS_N-1:0]      cells_q,
	output logic [POS_W-1:0]           len_q
);

	logic [PATTERN_MAX*8+7:0] pat_ext;
	logic [POS_W-1:0] len_used;
	pat_cell_t [POS_N-1:0] cells_d;

	assign pat_ext = {8'h00, pattern};
	assign len_used = (pattern_length > 6'(PATTERN_MAX)) ? POS_W'(PATTERN_MAX)
		: POS_W'(pattern_length);

	always_comb begin
		logic [7:0] b;
		logic [7:0] nb;
		for (int i = 0; i < POS_N; i++) begin
			cells_d[i].kind = K_NONE;
			cells_d[i].lit_ch = 8'h00;
		end
		for (int i = 0; i < PATTERN_MAX; i++) begin
			b = pat_ext[i*8 +: 8];
			nb = pat_ext[(i+1)*8 +: 8];
			cells_d[i].lit_ch = fold_case(b);
			if (POS_W'(i) < len_used) begin
				if (b == CH_STAR) begin
					cells_d[i].kind = K_STAR;
				end else if (b == CH_ANY) begin
					cells_d[i].kind = K_ANY;
				end else if (b == CH_ESC) begin
					// escape at the last position in use never matches
					if (POS_W'(i + 1) < len_used) begin
						cells_d[i].kind = K_ESC;
						cells_d[i].lit_ch = fold_case(nb);
					end
				end else begin
					cells_d[i].kind = K_LIT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cells_q <= cells_d;
		len_q <= len_used;
	end

endmodule

@@ rtl/wgm_cell.sv @@
// One pattern position: holds its reached bit and hands moves to its neighbors.
module wgm_cell import wgm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pat_cell_t  pat,
	input  logic [7:0] fchar,
	input  logic       restart,
	input  logic       start_bit,
	input  logic       load,
	input  logic       next_bit,
	output cell_link_t link
);

	logic act_q;
	logic eff;
	logic hit;

	assign eff = restart ? start_bit : act_q;
	assign hit = (pat.lit_ch == fchar);

	always_comb begin
		link = '0;
		case (pat.kind)
			K_STAR: link.stay = eff;
			K_ANY:  link.step1 = eff;
			K_LIT:  link.step1 = eff & hit;
			K_ESC:  link.step2 = eff & hit;
			default: link = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (load) begin
			act_q <= next_bit;
		end
	end

endmodule

@@ rtl/wildcard_glob_matcher_top.sv @@
// Top level of the wildcard glob matcher: APB pattern registers, cell row, result register.
//
// The block tests a name, streamed one byte per transfer on the char channel, against a
// wildcard pattern of up to 32 bytes held in APB registers ('*' any run, '?' one
// character, backslash makes the next byte literal, letters compare case-insensitively).
// A row of 33 cells, one per pattern position, holds the set of reached positions; every
// accepted byte moves the whole set one step, and a log-depth star closure completes it in
// the same cycle, so one byte is taken every clock. The transfer carrying last_char
// produces one result transfer (matched) and returns the row to the start set. Non-last
// bytes never wait on the result side; a last byte waits only while a previous result is
// still held and not being taken. After reset and after each register write the char
// channel drops ready while the decode registers and then the start-set register settle;
// a write also drops any name in progress. Registers sit at byte address 8*i: pattern
// bytes 0-7, 8-15, 16-23, 24-31 (byte 0 in the low bits), then the pattern length.
module wildcard_glob_matcher_top import wgm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// name byte channel
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic        matched
);

	logic [63:0] pat_a_q;
	logic [63:0] pat_b_q;
	logic [63:0] pat_c_q;
	logic [63:0] pat_d_q;
	logic [5:0]  plen_q;

	logic [2:0] reg_idx;
	logic       cfg_wr;
	logic [1:0] settle_q;
	logic       restart_q;
	logic [POS_N-1:0] start_q;
	logic       out_valid_q;
	logic       matched_s1;

	pat_cell_t [POS_N-1:0] cells;
	logic [POS_W-1:0] len_q;
	cell_link_t [POS_N-1:0] links;
	logic [POS_N-1:0] star_prop;
	logic [POS_N-1:0] raw_next;
	logic [POS_N-1:0] closed_next;
	logic [POS_N-1:0] start_set;
	logic [7:0] fchar;
	logic char_fire;

	// ---------------- configuration registers ----------------
	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr = psel & penable & pwrite & pready &
		(reg_idx == REG_PAT_A || reg_idx == REG_PAT_B || reg_idx == REG_PAT_C ||
		 reg_idx == REG_PAT_D || reg_idx == REG_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_a_q <= '0;
			pat_b_q <= '0;
			pat_c_q <= '0;
			pat_d_q <= '0;
			plen_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PAT_A: pat_a_q <= pwdata;
				REG_PAT_B: pat_b_q <= pwdata;
				REG_PAT_C: pat_c_q <= pwdata;
				REG_PAT_D: pat_d_q <= pwdata;
				REG_LEN:   plen_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT_A: prdata = pat_a_q;
			REG_PAT_B: prdata = pat_b_q;
			REG_PAT_C: prdata = pat_c_q;
			REG_PAT_D: prdata = pat_d_q;
			REG_LEN:   prdata = {58'd0, plen_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------- pattern decode and start set ----------------
	wgm_decode u_decode (
		.clk            (clk),
		.pattern        ({pat_d_q, pat_c_q, pat_b_q, pat_a_q}),
		.pattern_length (plen_q),
		.cells_q        (cells),
		.len_q          (len_q)
	);

	// a star at position j-1 carries a reached bit on to position j
	always_comb begin
		star_prop[0] = 1'b0;
		for (int j = 1; j < POS_N; j++) begin
			star_prop[j] = (cells[j-1].kind == K_STAR);
		end
	end

	wgm_closure u_start_closure (
		.set_in  (POS_N'(1)),
		.prop    (star_prop),
		.set_out (start_set)
	);

	// settle: decode registers, then start set, before bytes may enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (cfg_wr) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_set;
	end

	// ---------------- cell row ----------------
	assign char_ready = (settle_q == 2'd0) & (~last_char | ~out_valid_q | result_ready);
	assign char_fire = char_valid & char_ready;
	assign fchar = fold_case(char_code);

	for (genvar i = 0; i < POS_N; i++) begin : g_cell
		wgm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.pat       (cells[i]),
			.fchar     (fchar),
			.restart   (restart_q),
			.start_bit (start_q[i]),
			.load      (char_fire),
			.next_bit  (closed_next[i]),
			.link      (links[i])
		);
	end

	// gather each position's moves: stay on a star, one step, or two past an escape
	always_comb begin
		for (int j = 0; j < POS_N; j++) begin
			raw_next[j] = links[j].stay;
			if (j >= 1) begin
				raw_next[j] = raw_next[j] | links[j-1].step1;
			end
			if (j >= 2) begin
				raw_next[j] = raw_next[j] | links[j-2].step2;
			end
		end
	end

	wgm_closure u_step_closure (
		.set_in  (raw_next),
		.prop    (star_prop),
		.set_out (closed_next)
	);

	// return to the start set after the last byte of a name or a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
		end else if (cfg_wr) begin
			restart_q <= 1'b1;
		end else if (char_fire) begin
			restart_q <= last_char;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (char_fire & last_char) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_fire & last_char) begin
			matched_s1 <= closed_next[len_q];
		end
	end

	assign result_valid = out_valid_q;
	assign matched = matched_s1;

	// ---------------- assertions ----------------
	// no byte may enter right after a write, before the new start set exists
	assert property (@(posedge clk) disable iff (!arst_n) cfg_wr |=> !char_fire)
		else $error("byte accepted before pattern settled");

	// a last byte always leaves a result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(char_fire & last_char) |=> result_valid)
		else $error("last byte produced no result");

	// a last byte is never taken over a held result that is not leaving
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid & !result_ready) |-> !(char_fire & last_char))
		else $error("result overwritten");

	// the reached set never extends past the end of the pattern
	assert property (@(posedge clk) disable iff (!arst_n)
		(settle_q == 2'd0) |-> (((closed_next >> len_q) >> 1) == '0))
		else $error("position reached beyond pattern length");

endmodule
